// ===== hw/rtl/dclc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dclc_pkg;

  localparam int NUM_CH    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 5;

  localparam logic [3:0] OP_ON     = 4'd0;
  localparam logic [3:0] OP_OFF    = 4'd1;
  localparam logic [3:0] OP_TOGGLE = 4'd2;
  localparam logic [3:0] OP_LEVEL  = 4'd3;
  localparam logic [3:0] OP_MOVE   = 4'd4;
  localparam logic [3:0] OP_STEP   = 4'd5;
  localparam logic [3:0] OP_XY     = 4'd6;
  localparam logic [3:0] OP_TEMP   = 4'd7;
  localparam logic [3:0] OP_MODE   = 4'd8;

  localparam logic [1:0] MODE_XY   = 2'd1;
  localparam logic [1:0] MODE_TEMP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SUP_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUP_XY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUP_TEMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MASK  = 3'd5;

  localparam logic [7:0]  MAX_LEVEL    = 8'd254;
  localparam logic [15:0] MIRED_LOW    = 16'd153;
  localparam logic [15:0] MIRED_HIGH   = 16'd500;
  localparam logic [15:0] XY_THRESHOLD = 16'd40000;
  localparam logic [15:0] RESET_MIRED  = 16'd370;
  localparam logic [6:0]  PCT_FULL     = 7'd100;
  localparam logic [6:0]  PCT_HALF     = 7'd50;

  // floor(n/254) = (n * 66053) >> 24, folded with *100
  localparam logic [22:0] BRIGHT_RECIP = 23'd6605300;
  // floor(n/347) = (n * 48350) >> 24, folded with *100
  localparam logic [22:0] TEMP_RECIP   = 23'd4835000;
  // floor(n/100) = (n * 41944) >> 22 for n <= 10000
  localparam logic [15:0] PCT_RECIP    = 16'd41944;

  typedef struct packed {
    logic capture;
    logic stage1;
    logic stage2;
    logic load_out;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dclc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dclc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dclc_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC1 = 2'd1;
  localparam logic [1:0] S_CALC2 = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_ready     = (state == S_IDLE);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.stage1   = (state == S_CALC1);
  assign cmd.stage2   = (state == S_CALC2);
  assign cmd.load_out = (state == S_LOAD) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_CALC1;
      S_CALC1: state_next = S_CALC2;
      S_CALC2: state_next = S_LOAD;
      S_LOAD:  if (cmd.load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dclc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dclc_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire dclc_pkg::cmd_t                     cmd,
  input  wire logic                               cfg_we,
  input  wire logic [dclc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [dclc_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic [3:0]                         opcode,
  input  wire logic                               level_sets_on,
  input  wire logic [7:0]                         target_level,
  input  wire logic                               direction,
  input  wire logic [7:0]                         step_size,
  input  wire logic [15:0]                        color_x,
  input  wire logic [15:0]                        color_y,
  input  wire logic [15:0]                        mired_value,
  input  wire logic [1:0]                         mode_value,
  output logic [6:0]                              duty_red,
  output logic [6:0]                              duty_green,
  output logic [6:0]                              duty_blue,
  output logic [6:0]                              duty_cold,
  output logic [6:0]                              duty_warm,
  output logic [4:0]                              channel_enable,
  output logic                                    light_on,
  output logic [7:0]                              current_level,
  output logic                                    status
);

  logic       sup_level;
  logic       sup_xy;
  logic       sup_temp;
  logic [4:0] pin_mask;
  logic [4:0] high_mask;
  logic [4:0] pwm_mask;

  logic        on_flag;
  logic [7:0]  level;
  logic [15:0] x_val;
  logic [15:0] y_val;
  logic [15:0] mired;
  logic [1:0]  mode;
  logic        status_q;

  logic        on_flag_next;
  logic [7:0]  level_next;
  logic [15:0] x_val_next;
  logic [15:0] y_val_next;
  logic [15:0] mired_next;
  logic [1:0]  mode_next;
  logic        status_next;

  logic        level_en;
  logic [8:0]  level_sum;
  logic [7:0]  new_level;
  logic        set_level;

  assign level_en  = sup_level | sup_xy | sup_temp;
  assign level_sum = {1'b0, level} + {1'b0, step_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      sup_level <= 1'b0;
      sup_xy    <= 1'b0;
      sup_temp  <= 1'b0;
      pin_mask  <= 5'd0;
      high_mask <= 5'd31;
      pwm_mask  <= 5'd31;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dclc_pkg::REG_SUP_LEVEL: sup_level <= cfg_wdata[0];
        dclc_pkg::REG_SUP_XY:    sup_xy    <= cfg_wdata[0];
        dclc_pkg::REG_SUP_TEMP:  sup_temp  <= cfg_wdata[0];
        dclc_pkg::REG_PIN_MASK:  pin_mask  <= cfg_wdata;
        dclc_pkg::REG_HIGH_MASK: high_mask <= cfg_wdata;
        dclc_pkg::REG_PWM_MASK:  pwm_mask  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    new_level = level;
    unique case (opcode)
      dclc_pkg::OP_LEVEL:
        new_level = (target_level > dclc_pkg::MAX_LEVEL) ? dclc_pkg::MAX_LEVEL : target_level;
      dclc_pkg::OP_MOVE:
        new_level = direction ? 8'd0 : dclc_pkg::MAX_LEVEL;
      dclc_pkg::OP_STEP:
        if (direction) begin
          new_level = (level > step_size) ? (level - step_size) : 8'd0;
        end else begin
          new_level = (level_sum > {1'b0, dclc_pkg::MAX_LEVEL}) ? dclc_pkg::MAX_LEVEL
                                                                : level_sum[7:0];
        end
      default: new_level = level;
    endcase
  end

  always_comb begin
    on_flag_next = on_flag;
    level_next   = level;
    x_val_next   = x_val;
    y_val_next   = y_val;
    mired_next   = mired;
    mode_next    = mode;
    status_next  = 1'b0;
    set_level    = 1'b0;
    unique case (opcode) inside
      dclc_pkg::OP_ON:     on_flag_next = 1'b1;
      dclc_pkg::OP_OFF:    on_flag_next = 1'b0;
      dclc_pkg::OP_TOGGLE: on_flag_next = ~on_flag;
      dclc_pkg::OP_LEVEL, dclc_pkg::OP_MOVE, dclc_pkg::OP_STEP: begin
        if (!level_en) begin
          status_next = 1'b1;
        end else begin
          set_level = 1'b1;
        end
      end
      dclc_pkg::OP_XY: begin
        if (!sup_xy && !sup_temp) begin
          status_next = 1'b1;
        end else if (sup_xy) begin
          x_val_next = color_x;
          y_val_next = color_y;
          mode_next  = dclc_pkg::MODE_XY;
        end
      end
      dclc_pkg::OP_TEMP: begin
        if (!sup_xy && !sup_temp) begin
          status_next = 1'b1;
        end else if (sup_temp) begin
          mired_next = mired_value;
          mode_next  = dclc_pkg::MODE_TEMP;
        end
      end
      dclc_pkg::OP_MODE: mode_next = mode_value;
      default: ;
    endcase
    if (set_level) begin
      level_next = new_level;
      if (level_sets_on) begin
        on_flag_next = (new_level != 8'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_flag <= 1'b0;
      level   <= dclc_pkg::MAX_LEVEL;
      x_val   <= 16'd0;
      y_val   <= 16'd0;
      mired   <= dclc_pkg::RESET_MIRED;
      mode    <= dclc_pkg::MODE_TEMP;
    end else if (cmd.capture) begin
      on_flag <= on_flag_next;
      level   <= level_next;
      x_val   <= x_val_next;
      y_val   <= y_val_next;
      mired   <= mired_next;
      mode    <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_q <= status_next;
    end
  end

  // stage 1: brightness, per-channel percent, active group
  logic              lit;
  logic [30:0]       bright_prod;
  logic [6:0]        bright;
  logic [22:0]       x_scaled;
  logic [22:0]       y_scaled;
  logic [22:0]       x_sum;
  logic [22:0]       y_sum;
  logic [6:0]        x_pct;
  logic [6:0]        y_pct;
  logic [8:0]        mired_off;
  logic [31:0]       ww_prod;
  logic [6:0]        ww_pct;
  logic [4:0][6:0]   pct_d;
  logic [4:0]        group_d;
  logic [6:0]        bright_q;
  logic [4:0][6:0]   pct_q;
  logic [4:0]        group_q;

  assign lit         = on_flag && (!level_en || (level != 8'd0));
  assign bright_prod = 31'(level) * 31'(dclc_pkg::BRIGHT_RECIP);
  assign bright      = level_en ? bright_prod[30:24] : dclc_pkg::PCT_FULL;

  // n / 65535 == (n + (n >> 16) + 1) >> 16 for these ranges
  assign x_scaled = 23'(x_val) * 23'd100;
  assign y_scaled = 23'(y_val) * 23'd100;
  assign x_sum    = x_scaled + 23'(x_scaled[22:16]) + 23'd1;
  assign y_sum    = y_scaled + 23'(y_scaled[22:16]) + 23'd1;
  assign x_pct    = x_sum[22:16];
  assign y_pct    = y_sum[22:16];

  assign mired_off = mired[8:0] - dclc_pkg::MIRED_LOW[8:0];
  assign ww_prod   = 32'(mired_off) * 32'(dclc_pkg::TEMP_RECIP);
  assign ww_pct    = ww_prod[30:24];

  always_comb begin
    pct_d   = '0;
    group_d = 5'd0;
    if (lit && (mode == dclc_pkg::MODE_XY)) begin
      group_d = 5'b00111;
      if (x_val > dclc_pkg::XY_THRESHOLD) begin
        pct_d[0] = dclc_pkg::PCT_FULL;
        pct_d[1] = y_pct;
      end else if (y_val > dclc_pkg::XY_THRESHOLD) begin
        pct_d[0] = x_pct;
        pct_d[1] = dclc_pkg::PCT_FULL;
      end else begin
        pct_d[0] = x_pct;
        pct_d[1] = y_pct;
        pct_d[2] = dclc_pkg::PCT_FULL;
      end
    end else if (lit && (mode == dclc_pkg::MODE_TEMP)) begin
      group_d = 5'b11000;
      if (mired <= dclc_pkg::MIRED_LOW) begin
        pct_d[3] = dclc_pkg::PCT_FULL;
      end else if (mired >= dclc_pkg::MIRED_HIGH) begin
        pct_d[4] = dclc_pkg::PCT_FULL;
      end else begin
        pct_d[4] = ww_pct;
        pct_d[3] = dclc_pkg::PCT_FULL - ww_pct;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage1) begin
      bright_q <= bright;
      pct_q    <= pct_d;
      group_q  <= group_d & pin_mask;
    end
  end

  // stage 2: percent times brightness
  logic [4:0][13:0] prod_q;
  logic [4:0]       en_q;

  always_ff @(posedge clk) begin
    if (cmd.stage2) begin
      for (int i = 0; i < dclc_pkg::NUM_CH; i++) begin
        prod_q[i] <= 14'(pct_q[i]) * 14'(bright_q);
      end
      en_q <= group_q;
    end
  end

  // stage 3: divide by 100, apply pin polarity and on/off pins
  logic [4:0][29:0] scaled;
  logic [4:0][6:0]  duty_d;

  always_comb begin
    for (int i = 0; i < dclc_pkg::NUM_CH; i++) begin
      scaled[i] = 30'(prod_q[i]) * 30'(dclc_pkg::PCT_RECIP);
      duty_d[i] = 7'd0;
      if (en_q[i]) begin
        if (pwm_mask[i]) begin
          duty_d[i] = high_mask[i] ? scaled[i][28:22] : (dclc_pkg::PCT_FULL - scaled[i][28:22]);
        end else begin
          duty_d[i] = ((scaled[i][28:22] > dclc_pkg::PCT_HALF) == high_mask[i]) ?
                      dclc_pkg::PCT_FULL : 7'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      duty_red       <= duty_d[0];
      duty_green     <= duty_d[1];
      duty_blue      <= duty_d[2];
      duty_cold      <= duty_d[3];
      duty_warm      <= duty_d[4];
      channel_enable <= en_q;
      light_on       <= on_flag;
      current_level  <= level;
      status         <= status_q;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dimmable_color_light_controller_top.sv =====
// Dimmable color light controller.
// Input channel (in_valid/in_ready) carries one light command per transaction:
// opcode plus its operands. Output channel (out_valid/out_ready) returns one
// transaction per command with five pin duties, the channel enables, the
// stored on flag and level, and a skipped status.
// Configuration is a write port (cfg_we, cfg_addr, cfg_wdata); there is no
// read-back. The user must write it only while no command is in flight; the
// block itself does not enforce this. A command updates the stored light
// state as it is accepted; its result then passes through the stage 1 and
// stage 2 registers to the output register, which loads when it is free. The
// three-step scaling chain (brightness/percent, percent times brightness,
// divide by 100 and polarity) is run by the controller one command at a time.
// A result waiting in the output register does not block the next command;
// if the receiver stalls, the following result waits in the last step and
// in_ready stays low until the output register is taken.
// Reset: synchronous, active high. Registers return to supports off, no pins,
// active high PWM on all channels; light off, level 254, temperature mode at
// 370 mireds; no result pending.
`timescale 1ns / 1ps
`default_nettype none
module dimmable_color_light_controller_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [3:0]                         opcode,
  input  wire logic                               level_sets_on,
  input  wire logic [7:0]                         target_level,
  input  wire logic                               direction,
  input  wire logic [7:0]                         step_size,
  input  wire logic [15:0]                        color_x,
  input  wire logic [15:0]                        color_y,
  input  wire logic [15:0]                        mired_value,
  input  wire logic [1:0]                         mode_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [6:0]                              duty_red,
  output logic [6:0]                              duty_green,
  output logic [6:0]                              duty_blue,
  output logic [6:0]                              duty_cold,
  output logic [6:0]                              duty_warm,
  output logic [4:0]                              channel_enable,
  output logic                                    light_on,
  output logic [7:0]                              current_level,
  output logic                                    status,
  input  wire logic                               cfg_we,
  input  wire logic [dclc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [dclc_pkg::CFG_W-1:0]         cfg_wdata
);

  dclc_pkg::cmd_t cmd;

  dclc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dclc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .opcode         (opcode),
    .level_sets_on  (level_sets_on),
    .target_level   (target_level),
    .direction      (direction),
    .step_size      (step_size),
    .color_x        (color_x),
    .color_y        (color_y),
    .mired_value    (mired_value),
    .mode_value     (mode_value),
    .duty_red       (duty_red),
    .duty_green     (duty_green),
    .duty_blue      (duty_blue),
    .duty_cold      (duty_cold),
    .duty_warm      (duty_warm),
    .channel_enable (channel_enable),
    .light_on       (light_on),
    .current_level  (current_level),
    .status         (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted transaction");

  a_enable_needs_on: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (channel_enable != 5'd0)) |-> light_on)
    else $error("channel driven while light is off");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (current_level <= dclc_pkg::MAX_LEVEL))
    else $error("stored level above maximum");

  a_undriven_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !channel_enable[0]) |-> (duty_red == 7'd0))
    else $error("undriven red channel has nonzero duty");

endmodule
`default_nettype wire

// ===== tb/dimmable_color_light_controller_top_tb.sv =====
`timescale 1ns / 1ps
module dimmable_color_light_controller_top_tb;
  import dclc_pkg::*;

  localparam logic [1:0] MODE_HUESAT   = 2'd0;
  localparam logic [1:0] MODE_RSVD     = 2'd3;
  localparam logic [3:0] OP_UNUSED_LO  = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI  = 4'd15;
  localparam logic       ST_DONE       = 1'b0;
  localparam logic       ST_SKIP       = 1'b1;
  localparam logic [4:0] RGB_GROUP     = 5'b00111;
  localparam logic [4:0] WHITE_GROUP   = 5'b11000;
  localparam int         XY_FULL       = 65535;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         PHASE_ITEMS   = 90;
  localparam int         NUM_PHASES    = 10;
  localparam int         NO_GAP_PHASE  = 5;
  localparam int         DIR_CFG_AT    = 6;

  typedef struct packed {
    logic [3:0]  opcode;
    logic        level_sets_on;
    logic [7:0]  target_level;
    logic        direction;
    logic [7:0]  step_size;
    logic [15:0] color_x;
    logic [15:0] color_y;
    logic [15:0] mired_value;
    logic [1:0]  mode_value;
  } light_cmd_t;

  typedef struct packed {
    logic [6:0] red;
    logic [6:0] green;
    logic [6:0] blue;
    logic [6:0] cold;
    logic [6:0] warm;
    logic [4:0] enable;
    logic       on;
    logic [7:0] level;
    logic       status;
  } light_result_t;

  typedef struct packed {
    logic       sup_level;
    logic       sup_xy;
    logic       sup_temp;
    logic [4:0] pins;
    logic [4:0] high;
    logic [4:0] pwm;
  } light_cfg_t;

  typedef struct packed {
    light_cmd_t    c;
    logic          typed;
    light_result_t r;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [3:0]           opcode = '0;
  logic                 level_sets_on = 1'b0;
  logic [7:0]           target_level = '0;
  logic                 direction = 1'b0;
  logic [7:0]           step_size = '0;
  logic [15:0]          color_x = '0;
  logic [15:0]          color_y = '0;
  logic [15:0]          mired_value = '0;
  logic [1:0]           mode_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [6:0]           duty_red;
  logic [6:0]           duty_green;
  logic [6:0]           duty_blue;
  logic [6:0]           duty_cold;
  logic [6:0]           duty_warm;
  logic [4:0]           channel_enable;
  logic                 light_on;
  logic [7:0]           current_level;
  logic                 status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // light state and registers as the block should hold them
  logic        m_on;
  int unsigned m_level;
  int unsigned m_x;
  int unsigned m_y;
  int unsigned m_mired;
  logic [1:0]  m_mode;
  light_cfg_t  m_cfg;

  light_result_t expected_lights[$];
  dir_row_t      dir_rows[$];

  logic gaps_on = 1'b1;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   cmds_sent = 0;
  int   results_seen = 0;
  int   lit_results = 0;
  int   skipped_results = 0;

  dimmable_color_light_controller_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .level_sets_on  (level_sets_on),
    .target_level   (target_level),
    .direction      (direction),
    .step_size      (step_size),
    .color_x        (color_x),
    .color_y        (color_y),
    .mired_value    (mired_value),
    .mode_value     (mode_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .duty_red       (duty_red),
    .duty_green     (duty_green),
    .duty_blue      (duty_blue),
    .duty_cold      (duty_cold),
    .duty_warm      (duty_warm),
    .channel_enable (channel_enable),
    .light_on       (light_on),
    .current_level  (current_level),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic reset_light_model();
    m_on    = 1'b0;
    m_level = MAX_LEVEL;
    m_x     = 0;
    m_y     = 0;
    m_mired = RESET_MIRED;
    m_mode  = MODE_TEMP;
    m_cfg   = '{1'b0, 1'b0, 1'b0, 5'd0, 5'd31, 5'd31};
  endtask

  function automatic light_result_t predict_light(light_cmd_t c);
    light_result_t r;
    int unsigned   pct [5];
    int unsigned   duties [5];
    int unsigned   nl;
    int unsigned   bright;
    int unsigned   d;
    logic [4:0]    group;
    logic          lvl_en;
    logic          lit;
    r      = '0;
    pct    = '{0, 0, 0, 0, 0};
    duties = '{0, 0, 0, 0, 0};
    group  = '0;
    bright = PCT_FULL;
    lvl_en = m_cfg.sup_level | m_cfg.sup_xy | m_cfg.sup_temp;
    r.status = ST_DONE;
    case (c.opcode) inside
      OP_ON: m_on = 1'b1;
      OP_OFF: m_on = 1'b0;
      OP_TOGGLE: m_on = ~m_on;
      OP_LEVEL, OP_MOVE, OP_STEP: begin
        if (!lvl_en) begin
          r.status = ST_SKIP;
        end else begin
          if (c.opcode == OP_LEVEL) nl = c.target_level;
          else if (c.opcode == OP_MOVE) nl = c.direction ? 0 : MAX_LEVEL;
          else if (c.direction) nl = (m_level > c.step_size) ? m_level - c.step_size : 0;
          else nl = m_level + c.step_size;
          m_level = (nl > MAX_LEVEL) ? MAX_LEVEL : nl;
          if (c.level_sets_on) m_on = (m_level > 0);
        end
      end
      OP_XY, OP_TEMP: begin
        if (!m_cfg.sup_xy && !m_cfg.sup_temp) begin
          r.status = ST_SKIP;
        end else if (c.opcode == OP_XY) begin
          if (m_cfg.sup_xy) begin
            m_x    = c.color_x;
            m_y    = c.color_y;
            m_mode = MODE_XY;
          end
        end else if (m_cfg.sup_temp) begin
          m_mired = c.mired_value;
          m_mode  = MODE_TEMP;
        end
      end
      OP_MODE: m_mode = c.mode_value;
      default: ;
    endcase

    lit = m_on;
    if (lvl_en) begin
      lit = lit && (m_level > 0);
      if (m_level == 0) bright = 0;
      else if (m_level >= MAX_LEVEL) bright = PCT_FULL;
      else bright = m_level * PCT_FULL / MAX_LEVEL;
    end

    if (lit && m_mode == MODE_XY) begin
      group = RGB_GROUP;
      if (m_x > XY_THRESHOLD) begin
        pct[0] = PCT_FULL;
        pct[1] = m_y * PCT_FULL / XY_FULL;
      end else if (m_y > XY_THRESHOLD) begin
        pct[0] = m_x * PCT_FULL / XY_FULL;
        pct[1] = PCT_FULL;
      end else begin
        pct[0] = m_x * PCT_FULL / XY_FULL;
        pct[1] = m_y * PCT_FULL / XY_FULL;
        pct[2] = PCT_FULL;
      end
    end else if (lit && m_mode == MODE_TEMP) begin
      group = WHITE_GROUP;
      if (m_mired <= MIRED_LOW) begin
        pct[3] = PCT_FULL;
      end else if (m_mired >= MIRED_HIGH) begin
        pct[4] = PCT_FULL;
      end else begin
        pct[4] = (m_mired - MIRED_LOW) * PCT_FULL / (MIRED_HIGH - MIRED_LOW);
        pct[3] = PCT_FULL - pct[4];
      end
    end

    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (group[ch] && m_cfg.pins[ch]) begin
        r.enable[ch] = 1'b1;
        d = pct[ch] * bright / PCT_FULL;
        if (m_cfg.pwm[ch]) duties[ch] = m_cfg.high[ch] ? d : PCT_FULL - d;
        else duties[ch] = ((d > PCT_HALF) == m_cfg.high[ch]) ? PCT_FULL : 0;
      end
    end
    r.red   = 7'(duties[0]);
    r.green = 7'(duties[1]);
    r.blue  = 7'(duties[2]);
    r.cold  = 7'(duties[3]);
    r.warm  = 7'(duties[4]);
    r.on    = m_on;
    r.level = 8'(m_level);
    return r;
  endfunction

  function automatic light_cmd_t mk_cmd(logic [3:0] op, logic wo, logic [7:0] tl, logic dir,
                                        logic [7:0] stp, logic [15:0] x, logic [15:0] y,
                                        logic [15:0] m, logic [1:0] mv);
    light_cmd_t c;
    c.opcode        = op;
    c.level_sets_on = wo;
    c.target_level  = tl;
    c.direction     = dir;
    c.step_size     = stp;
    c.color_x       = x;
    c.color_y       = y;
    c.mired_value   = m;
    c.mode_value    = mv;
    return c;
  endfunction

  // no channel driven: only on flag, level and status carry information
  function automatic light_result_t quiet(logic on, logic [7:0] lvl, logic st);
    light_result_t r;
    r        = '0;
    r.on     = on;
    r.level  = lvl;
    r.status = st;
    return r;
  endfunction

  function automatic dir_row_t row(light_cmd_t c, logic typed, light_result_t r);
    dir_row_t t;
    t.c     = c;
    t.typed = typed;
    t.r     = r;
    return t;
  endfunction

  function automatic light_cmd_t rand_cmd();
    light_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) c.opcode = OP_ON;
    else if (pick < 20) c.opcode = OP_OFF;
    else if (pick < 25) c.opcode = OP_TOGGLE;
    else if (pick < 40) c.opcode = OP_LEVEL;
    else if (pick < 48) c.opcode = OP_MOVE;
    else if (pick < 62) c.opcode = OP_STEP;
    else if (pick < 76) c.opcode = OP_XY;
    else if (pick < 90) c.opcode = OP_TEMP;
    else if (pick < 95) c.opcode = OP_MODE;
    else c.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    c.level_sets_on = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) c.target_level = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    else c.target_level = 8'($urandom_range(0, 255));
    c.direction = 1'($urandom_range(0, 1));
    c.step_size = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 40));
    c.color_x   = 16'($urandom_range(0, 65535));
    c.color_y   = 16'($urandom_range(0, 65535));
    // keep most temperatures around the interpolation window
    c.mired_value = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(100, 600));
    c.mode_value = 2'($urandom_range(0, 3));
    return c;
  endfunction

  function automatic light_cfg_t phase_cfg(int p);
    light_cfg_t s;
    case (p)
      0: s = '{1'b1, 1'b1, 1'b1, 5'd31, 5'd31, 5'd31};
      1: s = '{1'b0, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0};
      2: s = '{1'b0, 1'b1, 1'b0, 5'd31, 5'd0, 5'd31};
      3: s = '{1'b0, 1'b0, 1'b1, 5'd31, 5'd31, 5'd0};
      4: s = '{1'b1, 1'b0, 1'b0, 5'd31, 5'd31, 5'd31};
      5: s = '{1'b1, 1'b1, 1'b1, 5'd31, 5'd0, 5'd0};
      default: begin
        s.sup_level = 1'($urandom_range(0, 1));
        s.sup_xy    = 1'($urandom_range(0, 1));
        s.sup_temp  = 1'($urandom_range(0, 1));
        s.pins      = 5'($urandom_range(0, 31));
        s.high      = 5'($urandom_range(0, 31));
        s.pwm       = 5'($urandom_range(0, 31));
      end
    endcase
    return s;
  endfunction

  task automatic wait_drained();
    while (expected_lights.size() != 0) @(posedge clk);
  endtask

  task automatic load_cfg(light_cfg_t s);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_W-1:0]     val [6];
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    idx = '{REG_SUP_LEVEL, REG_SUP_XY, REG_SUP_TEMP, REG_PIN_MASK, REG_HIGH_MASK, REG_PWM_MASK};
    val = '{CFG_W'(s.sup_level), CFG_W'(s.sup_xy), CFG_W'(s.sup_temp), s.pins, s.high, s.pwm};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_cfg = s;
  endtask

  task automatic send_light_cmd(light_cmd_t c, logic typed, light_result_t fixed);
    light_result_t p;
    if (gaps_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= c.opcode;
    level_sets_on <= c.level_sets_on;
    target_level  <= c.target_level;
    direction     <= c.direction;
    step_size     <= c.step_size;
    color_x       <= c.color_x;
    color_y       <= c.color_y;
    mired_value   <= c.mired_value;
    mode_value    <= c.mode_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_light(c);
    expected_lights.push_back(typed ? fixed : p);
    cmds_sent++;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    light_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_lights.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with no command pending", $time);
      end else begin
        want = expected_lights.pop_front();
        check_field("duty_red", want.red, duty_red);
        check_field("duty_green", want.green, duty_green);
        check_field("duty_blue", want.blue, duty_blue);
        check_field("duty_cold", want.cold, duty_cold);
        check_field("duty_warm", want.warm, duty_warm);
        check_field("channel_enable", want.enable, channel_enable);
        check_field("light_on", want.on, light_on);
        check_field("current_level", want.level, current_level);
        check_field("status", want.status, status);
        results_seen++;
        if (want.enable != 0) lit_results++;
        if (want.status == ST_SKIP) skipped_results++;
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(0, 99) < 33);
    end
  end

  initial begin
    int k;
    int p;
    reset_light_model();

    // reset defaults: no level or color support, no pins
    dir_rows.push_back(row(mk_cmd(OP_ON, 0, 0, 0, 0, 0, 0, 0, 0), 1, quiet(1, 254, ST_DONE)));
    dir_rows.push_back(row(mk_cmd(OP_LEVEL, 1, 0, 0, 0, 0, 0, 0, 0), 1, quiet(1, 254, ST_SKIP)));
    dir_rows.push_back(row(mk_cmd(OP_STEP, 1, 0, 1, 255, 0, 0, 0, 0), 1, quiet(1, 254, ST_SKIP)));
    dir_rows.push_back(row(mk_cmd(OP_XY, 0, 0, 0, 0, 65535, 65535, 0, 0), 1,
                           quiet(1, 254, ST_SKIP)));
    dir_rows.push_back(row(mk_cmd(OP_TEMP, 0, 0, 0, 0, 0, 0, 153, 0), 1, quiet(1, 254, ST_SKIP)));
    dir_rows.push_back(row(mk_cmd(OP_UNUSED_HI, 1, 255, 1, 255, 65535, 65535, 65535, MODE_RSVD),
                           1, quiet(1, 254, ST_DONE)));
    // full support from here on
    dir_rows.push_back(row(mk_cmd(OP_TEMP, 0, 0, 0, 0, 0, 0, 153, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_TEMP, 0, 0, 0, 0, 0, 0, 500, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_TEMP, 0, 0, 0, 0, 0, 0, 65535, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_TEMP, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_TEMP, 0, 0, 0, 0, 0, 0, 326, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_LEVEL, 0, 255, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_STEP, 1, 0, 1, 255, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_STEP, 1, 0, 0, 255, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_MOVE, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_MOVE, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_LEVEL, 1, 127, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_XY, 0, 0, 0, 0, 65535, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_XY, 0, 0, 0, 0, 40000, 65535, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_XY, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_MODE, 0, 0, 0, 0, 0, 0, 0, MODE_HUESAT), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_MODE, 0, 0, 0, 0, 0, 0, 0, MODE_RSVD), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_MODE, 0, 0, 0, 0, 0, 0, 0, MODE_XY), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_OFF, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_rows.push_back(row(mk_cmd(OP_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < dir_rows.size(); k++) begin
      if (k == DIR_CFG_AT) begin
        in_valid <= 1'b0;
        load_cfg(phase_cfg(0));
      end
      send_light_cmd(dir_rows[k].c, dir_rows[k].typed, dir_rows[k].r);
    end
    in_valid <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      gaps_on <= (p != NO_GAP_PHASE);
      load_cfg(phase_cfg(p));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 20) hold_req <= hold_req + 1;
        if (p == 0 && k == 60) begin
          in_valid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
        send_light_cmd(rand_cmd(), 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d light commands over %0d register settings; %0d results checked,",
             cmds_sent, NUM_PHASES + 2, results_seen);
    $display("%0d with channels driven, %0d skipped as unsupported.",
             lit_results, skipped_results);
    if (mismatches == 0 && expected_lights.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
